@@ rtl/ffrs_pkg.sv @@
package ffrs_pkg;

  // Register indexes on the configuration port
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  // Transform codes held in the mode register
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_VFLIP = 3'd1;
  localparam logic [2:0] MODE_HFLIP = 3'd2;
  localparam logic [2:0] MODE_ROT90 = 3'd3;
  localparam logic [2:0] MODE_ROT180 = 3'd4;
  localparam logic [2:0] MODE_SCALE = 3'd5;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Frame store address, wide enough for the largest frame (64 x 64)
  localparam int ADDR_W = 12;
  // Reciprocal scaling: q = (v * ceil(2^RCP_SHIFT / s)) >> RCP_SHIFT is exact for v < 64
  localparam int RCP_SHIFT = 12;
  localparam int RCP_W = 13;
  localparam int PROD_W = 19;
  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       out_of_range;
  } out_t;

  // First front stage: coordinates classified, upscale products formed
  typedef struct packed {
    logic              rd;
    logic              hit;
    logic              scaled;
    logic [5:0]        sr;
    logic [5:0]        sc;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_c;
    logic [7:0]        data;
  } stage_t;

  // Work item handed from front to back
  typedef struct packed {
    logic              rd;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } job_t;

  // ceil(4096 / s) for s in 1..16
  function automatic logic [RCP_W-1:0] recip(input logic [4:0] s);
    logic [RCP_W-1:0] r;
    unique case (s)
      5'd2:    r = 13'd2048;
      5'd3:    r = 13'd1366;
      5'd4:    r = 13'd1024;
      5'd5:    r = 13'd820;
      5'd6:    r = 13'd683;
      5'd7:    r = 13'd586;
      5'd8:    r = 13'd512;
      5'd9:    r = 13'd456;
      5'd10:   r = 13'd410;
      5'd11:   r = 13'd373;
      5'd12:   r = 13'd342;
      5'd13:   r = 13'd316;
      5'd14:   r = 13'd293;
      5'd15:   r = 13'd274;
      5'd16:   r = 13'd256;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ffrs_front.sv @@
module ffrs_front #(
  parameter int ROWS = 8,
  parameter int COLS = 8,
  parameter int MAX_SCALE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          mode,
  input  logic [3:0]          scale_factor,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffrs_pkg::in_t       in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output ffrs_pkg::job_t      job
);

  ffrs_pkg::stage_t st1, st1_next;
  ffrs_pkg::job_t   st2, st2_next;
  logic             st1_valid, st2_valid;
  logic             st2_load;

  logic [4:0]                 s_eff;
  logic [ffrs_pkg::RCP_W-1:0] rcp;
  logic [10:0]                lim_h, lim_w;
  logic                       in_frame;
  logic [5:0]                 sr2;
  logic [5:0]                 sc2;

  assign st2_load = !st2_valid || job_ready;
  assign in_ready = !st1_valid || st2_load;

  // Classify the request and form the upscale products
  always_comb begin
    priority if (scale_factor == 4'd0) begin
      s_eff = 5'd1;
    end else if (5'(scale_factor) > 5'(MAX_SCALE)) begin
      s_eff = 5'(MAX_SCALE);
    end else begin
      s_eff = 5'(scale_factor);
    end
    rcp   = ffrs_pkg::recip(s_eff);
    lim_h = 11'(ROWS) * 11'(s_eff);
    lim_w = 11'(COLS) * 11'(s_eff);
    in_frame = (7'(in_data.row) < 7'(ROWS)) && (7'(in_data.col) < 7'(COLS));

    st1_next.rd     = in_data.cmd;
    st1_next.data   = in_data.pixel_in;
    st1_next.scaled = 1'b0;
    st1_next.sr     = in_data.row;
    st1_next.sc     = in_data.col;
    st1_next.prod_r = ffrs_pkg::PROD_W'(in_data.row) * ffrs_pkg::PROD_W'(rcp);
    st1_next.prod_c = ffrs_pkg::PROD_W'(in_data.col) * ffrs_pkg::PROD_W'(rcp);
    st1_next.hit    = in_frame;

    if (in_data.cmd == ffrs_pkg::CMD_READ) begin
      unique case (mode)
        ffrs_pkg::MODE_VFLIP: begin
          st1_next.sr = 6'(ROWS - 1) - in_data.row;
        end
        ffrs_pkg::MODE_HFLIP: begin
          st1_next.sc = 6'(COLS - 1) - in_data.col;
        end
        ffrs_pkg::MODE_ROT90: begin
          st1_next.hit = (7'(in_data.row) < 7'(COLS)) && (7'(in_data.col) < 7'(ROWS));
          st1_next.sr  = 6'(ROWS - 1) - in_data.col;
          st1_next.sc  = in_data.row;
        end
        ffrs_pkg::MODE_ROT180: begin
          st1_next.sr = 6'(ROWS - 1) - in_data.row;
          st1_next.sc = 6'(COLS - 1) - in_data.col;
        end
        ffrs_pkg::MODE_SCALE: begin
          st1_next.hit    = (11'(in_data.row) < lim_h) && (11'(in_data.col) < lim_w);
          st1_next.scaled = 1'b1;
        end
        default: begin
          st1_next.hit = in_frame;
        end
      endcase
    end
  end

  // Finish the quotient and form the frame store address
  always_comb begin
    sr2 = st1.scaled ? st1.prod_r[ffrs_pkg::RCP_SHIFT+5:ffrs_pkg::RCP_SHIFT] : st1.sr;
    sc2 = st1.scaled ? st1.prod_c[ffrs_pkg::RCP_SHIFT+5:ffrs_pkg::RCP_SHIFT] : st1.sc;
    st2_next.rd   = st1.rd;
    st2_next.hit  = st1.hit;
    st2_next.data = st1.data;
    st2_next.addr = ffrs_pkg::ADDR_W'(sr2) * ffrs_pkg::ADDR_W'(COLS)
                  + ffrs_pkg::ADDR_W'(sc2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        st1_valid <= in_valid;
      end
      if (st2_load) begin
        st2_valid <= st1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      st1 <= st1_next;
    end
    if (st2_load) begin
      st2 <= st2_next;
    end
  end

  assign job_valid = st2_valid;
  assign job       = st2;

endmodule

@@ rtl/ffrs_fifo.sv @@
module ffrs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  ffrs_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output ffrs_pkg::job_t head
);

  localparam int PW = $clog2(ffrs_pkg::QUEUE_DEPTH);

  ffrs_pkg::job_t slots [ffrs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_push, do_pop;

  assign push_ready = (count != (PW+1)'(ffrs_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/ffrs_back.sv @@
module ffrs_back #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ffrs_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output ffrs_pkg::out_t out_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] frame_store [DEPTH];
  logic [7:0] rd_data;
  logic       res_valid, res_oob;
  logic       slot_free;

  assign slot_free = !res_valid || out_ready;
  // Writes drain even while a read result is stalled
  assign pop = head_valid && ((head.rd == ffrs_pkg::CMD_WRITE) || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (slot_free) begin
      res_valid <= pop && (head.rd == ffrs_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.rd == ffrs_pkg::CMD_READ)) begin
      res_oob <= !head.hit;
      if (head.hit) begin
        rd_data <= frame_store[head.addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.rd == ffrs_pkg::CMD_WRITE) && head.hit) begin
      frame_store[head.addr[AW-1:0]] <= head.data;
    end
  end

  assign out_valid             = res_valid;
  assign out_data.pixel_out    = res_oob ? 8'd0 : rd_data;
  assign out_data.out_of_range = res_oob;

endmodule

@@ rtl/frame_flip_rotate_scale.sv @@
// Frame store of ROWS x COLS byte pixels with a transforming read path.
// Input channel (in_valid/in_ready/in_data): cmd 0 writes pixel_in at
// (row, col) of the source frame, ignored outside the frame; cmd 1 reads
// the pixel at output coordinate (row, col) of the frame transformed by the
// mode register (none, vertical flip, horizontal flip, rotate 90 cw,
// rotate 180, integer upscale by scale_factor).
// Output channel (out_valid/out_ready/out_data): one transfer per read,
// pixel_out zero and out_of_range set when the coordinate falls outside
// the transformed frame. Writes produce no transfer.
// Configuration: cfg_wr_en with cfg_index 0 (mode) or 1 (scale_factor); the
// user writes only while no item is in flight, not enforced by the block.
// Throughput: one item per cycle while out_ready stays high. An input
// transfer reaches out_valid through two front stages (classify/multiply,
// address), the 4-entry queue and the registered frame store read.
// Reset clears the pipeline and queue, mode to 0, scale_factor to 1; the
// frame store is not cleared and must be written before it is read.
// When out_ready is low the result holds, the queue fills behind it, and
// in_ready drops once the queue and front stages are full.
module frame_flip_rotate_scale #(
  parameter int ROWS = 8,
  parameter int COLS = 8,
  parameter int MAX_SCALE = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffrs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ffrs_pkg::out_t out_data
);

  logic [2:0]     mode;
  logic [3:0]     scale_factor;
  logic           job_valid, job_ready;
  ffrs_pkg::job_t job;
  logic           head_valid, pop;
  ffrs_pkg::job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ffrs_pkg::MODE_NONE;
      scale_factor <= 4'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ffrs_pkg::REG_MODE:  mode <= cfg_wdata[2:0];
        ffrs_pkg::REG_SCALE: scale_factor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ffrs_front #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .scale_factor (scale_factor),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job)
  );

  ffrs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ffrs_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ rtl/ffrs_checker.sv @@
module ffrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ffrs_pkg::out_t out_data
);

  // No result survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // Front stage is empty after reset, so input must be open
  a_reset_opens_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low right after reset");

  // Out-of-range reads carry a zero pixel
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_of_range) |-> (out_data.pixel_out == 8'd0))
    else $error("out_of_range result with nonzero pixel");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind frame_flip_rotate_scale ffrs_checker u_ffrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/frame_checker.sv @@
module frame_checker #(
  parameter int ROWS = 8,
  parameter int COLS = 8,
  parameter int MAX_SCALE = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_wdata,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ffrs_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ffrs_pkg::out_t out_data,
  output int             errors
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]     pixel_mirror [ROWS*COLS];
  logic [2:0]     mode_q = ffrs_pkg::MODE_NONE;
  logic [3:0]     scale_q = 4'd1;
  ffrs_pkg::out_t pending_pixels [$];
  int             mismatches = 0;
  int             leftover = 0;

  assign errors = mismatches + leftover;

  // Map an output coordinate back onto the source frame under the current transform
  function automatic ffrs_pkg::out_t transform_read(input logic [5:0] r, input logic [5:0] c);
    int             h, w, s, sr, sc;
    ffrs_pkg::out_t res;
    h = ROWS;
    w = COLS;
    s = 1;
    if (scale_q > 4'd1) s = (scale_q > MAX_SCALE) ? MAX_SCALE : scale_q;
    sr = r;
    sc = c;
    case (mode_q)
      ffrs_pkg::MODE_VFLIP: sr = ROWS - 1 - r;
      ffrs_pkg::MODE_HFLIP: sc = COLS - 1 - c;
      ffrs_pkg::MODE_ROT90: begin
        h = COLS;
        w = ROWS;
        sr = ROWS - 1 - c;
        sc = r;
      end
      ffrs_pkg::MODE_ROT180: begin
        sr = ROWS - 1 - r;
        sc = COLS - 1 - c;
      end
      ffrs_pkg::MODE_SCALE: begin
        h = ROWS * s;
        w = COLS * s;
        sr = r / s;
        sc = c / s;
      end
      default: ;
    endcase
    if (r < h && c < w && sr >= 0 && sr < ROWS && sc >= 0 && sc < COLS) begin
      res.pixel_out = pixel_mirror[sr*COLS + sc];
      res.out_of_range = 1'b0;
    end else begin
      res.pixel_out = 8'h00;
      res.out_of_range = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    ffrs_pkg::out_t want;
    if (rst) begin
      mode_q = ffrs_pkg::MODE_NONE;
      scale_q = 4'd1;
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: pixel %02h out_of_range %0b",
                     $time, out_data.pixel_out, out_data.out_of_range);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel_out !== want.pixel_out ||
              out_data.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: read mismatch: pixel exp %02h got %02h, out_of_range exp %0b got %0b",
                       $time, want.pixel_out, out_data.pixel_out,
                       want.out_of_range, out_data.out_of_range);
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == ffrs_pkg::REG_MODE) mode_q = cfg_wdata[2:0];
        else scale_q = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        if (in_data.cmd == ffrs_pkg::CMD_WRITE) begin
          // drop writes outside the source frame
          if (in_data.row < ROWS && in_data.col < COLS)
            pixel_mirror[in_data.row*COLS + in_data.col] = in_data.pixel_in;
        end else begin
          pending_pixels.push_back(transform_read(in_data.row, in_data.col));
        end
      end
    end
    leftover = pending_pixels.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int MAX_SCALE = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 100;

  // Unassigned mode codes, expected to behave as no transform
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_wr_en = 1'b0;
  logic           cfg_index = ffrs_pkg::REG_MODE;
  logic [3:0]     cfg_wdata = 4'd0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  ffrs_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ffrs_pkg::out_t out_data;
  int             errors;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int reads_sent = 0;
  int reads_done = 0;
  int row_lim = ROWS;
  int col_lim = COLS;
  int quiet_cycles = 0;

  logic [2:0] phase_mode [10] = '{ffrs_pkg::MODE_NONE, ffrs_pkg::MODE_VFLIP,
                                  ffrs_pkg::MODE_HFLIP, ffrs_pkg::MODE_ROT90,
                                  ffrs_pkg::MODE_ROT180, ffrs_pkg::MODE_SCALE,
                                  ffrs_pkg::MODE_SCALE, ffrs_pkg::MODE_SCALE,
                                  MODE_SPARE6, MODE_SPARE7};
  logic [3:0] phase_scale [10] = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd8, 4'd8, 4'd1, 4'd2,
                                   4'd4, 4'd12};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_flip_rotate_scale #(.ROWS(ROWS), .COLS(COLS), .MAX_SCALE(MAX_SCALE)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frame_checker #(.ROWS(ROWS), .COLS(COLS), .MAX_SCALE(MAX_SCALE)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Count results and end the run if transfers stop
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) reads_done <= reads_done + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(input logic cmd, input int r, input int c, input logic [7:0] p);
    ffrs_pkg::in_t item;
    item.cmd = cmd;
    item.row = r[5:0];
    item.col = c[5:0];
    item.pixel_in = p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (cmd == ffrs_pkg::CMD_READ) reads_sent++;
  endtask

  // Hold off until every read has returned and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (reads_done != reads_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] m, input logic [3:0] s);
    logic spare_bit;
    int   eff;
    spare_bit = 1'($urandom_range(1));
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= ffrs_pkg::REG_MODE;
    cfg_wdata <= {spare_bit, m};
    @(posedge clk);
    cfg_index <= ffrs_pkg::REG_SCALE;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eff = (s == 4'd0) ? 1 : (s > MAX_SCALE) ? MAX_SCALE : s;
    row_lim = (m == ffrs_pkg::MODE_ROT90) ? COLS : ROWS;
    col_lim = (m == ffrs_pkg::MODE_ROT90) ? ROWS : COLS;
    if (m == ffrs_pkg::MODE_SCALE) begin
      row_lim *= eff;
      col_lim *= eff;
    end
    // one past the frame edge, capped at the coordinate range
    if (row_lim > 63) row_lim = 63;
    if (col_lim > 63) col_lim = 63;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int r, c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corners first, then writes that fall outside the frame
    put(ffrs_pkg::CMD_WRITE, 0, 0, 8'h00);
    put(ffrs_pkg::CMD_WRITE, 0, COLS - 1, 8'hFF);
    put(ffrs_pkg::CMD_WRITE, ROWS - 1, 0, 8'hA5);
    put(ffrs_pkg::CMD_WRITE, ROWS - 1, COLS - 1, 8'h5A);
    put(ffrs_pkg::CMD_WRITE, 63, 63, 8'h3C);
    put(ffrs_pkg::CMD_WRITE, 0, COLS, 8'hC3);

    // corners map onto corners under every flip and rotation
    for (int m = 0; m < 5; m++) begin
      configure(m[2:0], 4'd1);
      put(ffrs_pkg::CMD_READ, 0, 0, rand_byte());
      put(ffrs_pkg::CMD_READ, ROWS - 1, COLS - 1, rand_byte());
      if (m % 2 == 0) put(ffrs_pkg::CMD_READ, ROWS, 0, rand_byte());
      else put(ffrs_pkg::CMD_READ, 63, 63, rand_byte());
    end
    configure(MODE_SPARE6, 4'd1);
    put(ffrs_pkg::CMD_READ, ROWS - 1, 0, rand_byte());
    configure(MODE_SPARE7, 4'd0);
    put(ffrs_pkg::CMD_READ, 0, COLS - 1, rand_byte());
    configure(ffrs_pkg::MODE_SCALE, 4'd0);
    put(ffrs_pkg::CMD_READ, ROWS - 1, COLS - 1, rand_byte());
    put(ffrs_pkg::CMD_READ, 0, COLS, rand_byte());
    configure(ffrs_pkg::MODE_SCALE, 4'd15);
    put(ffrs_pkg::CMD_READ, 63, 63, rand_byte());
    put(ffrs_pkg::CMD_READ, 0, 63, rand_byte());

    // fill the whole frame so any in-range read is defined from here on
    for (int i = 0; i < ROWS * COLS; i++)
      put(ffrs_pkg::CMD_WRITE, i / COLS, i % COLS, rand_byte());

    for (int k = 0; k < PHASES; k++) begin
      if (k < 10) configure(phase_mode[k], phase_scale[k]);
      else configure(3'($urandom_range(7)), 4'($urandom_range(15)));
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 60) begin
          r = ($urandom_range(9) < 8) ? $urandom_range(row_lim) : $urandom_range(63);
          c = ($urandom_range(9) < 8) ? $urandom_range(col_lim) : $urandom_range(63);
          put(ffrs_pkg::CMD_READ, r, c, rand_byte());
        end else begin
          r = ($urandom_range(9) < 9) ? $urandom_range(ROWS - 1) : $urandom_range(63);
          c = ($urandom_range(9) < 9) ? $urandom_range(COLS - 1) : $urandom_range(63);
          put(ffrs_pkg::CMD_WRITE, r, c, rand_byte());
        end
      end
    end

    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ffrs_pkg.sv
rtl/ffrs_front.sv
rtl/ffrs_fifo.sv
rtl/ffrs_back.sv
rtl/frame_flip_rotate_scale.sv
rtl/ffrs_checker.sv
tb/frame_checker.sv
tb/tb_top.sv
